/* hw/rtl/tmic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmic_pkg: shared types and constants of the trimmed mean ID classifier
// Holds the group statistics word passed from the front end to the back end,
// the level thresholds with their class codes, and the classification function.
// ----------------------------------------------------------------------------
package tmic_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 14;
    localparam int CLASS_W  = 5;
    localparam int INDEX_W  = 4;

    // Samples per group. The index of the last sample closes the group.
    localparam int GROUP_SIZE = 10;
    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(GROUP_SIZE - 1);

    // Running minimum starts at full scale.
    localparam logic [SAMPLE_W-1:0] MIN_INIT = '1;

    // Descending chain of strict thresholds and the class each one selects.
    localparam int THRESH_COUNT = 23;
    localparam logic [SAMPLE_W-1:0] LEVEL_BOUND [0:THRESH_COUNT-1] = '{
        10'd1010, 10'd970, 10'd950, 10'd930, 10'd900, 10'd875, 10'd800,
        10'd766,  10'd720, 10'd670, 10'd620, 10'd590, 10'd530, 10'd500,
        10'd480,  10'd465, 10'd422, 10'd405, 10'd379, 10'd345, 10'd305,
        10'd270,  10'd207
    };
    localparam logic [CLASS_W-1:0] BOUND_CLASS [0:THRESH_COUNT-1] = '{
        5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
        5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd2,
        5'd15, 5'd16, 5'd17, 5'd2,  5'd18, 5'd19, 5'd20
    };

    // Class for levels at or below the lowest threshold: the shared other kind.
    localparam logic [CLASS_W-1:0] LOW_CLASS = 5'd2;

    // Statistics of one completed group.
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] max;
        logic [SAMPLE_W-1:0] min;
    } group_stats_t;

    // The first threshold that the level exceeds picks the class. The compares
    // are independent; the loop only builds a priority select.
    function automatic logic [CLASS_W-1:0] classify(input logic [SAMPLE_W-1:0] level);
        logic [CLASS_W-1:0] result;
        result = LOW_CLASS;
        for (int i = THRESH_COUNT - 1; i >= 0; i--) begin
            if (level > LEVEL_BOUND[i]) begin
                result = BOUND_CLASS[i];
            end
        end
        return result;
    endfunction

endpackage

/* hw/rtl/tmic_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmic_front: sample accumulator
// Keeps the running sum, maximum and minimum of the current group and hands
// the statistics of each completed group to the queue.
// ----------------------------------------------------------------------------
module tmic_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tmic_pkg::SAMPLE_W-1:0]        s_sample,
    output logic                                 push,
    output tmic_pkg::group_stats_t               push_data,
    input  logic                                 q_full
);

    logic [tmic_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [tmic_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [tmic_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic [tmic_pkg::SAMPLE_W-1:0] min_reg, min_next;

    logic [tmic_pkg::SUM_W-1:0]    sum_add;
    logic [tmic_pkg::SAMPLE_W-1:0] max_upd;
    logic [tmic_pkg::SAMPLE_W-1:0] min_upd;
    logic                          last_sample;
    logic                          accept;

    // Statistics including the incoming word.
    assign sum_add = sum_reg + tmic_pkg::SUM_W'(s_sample);
    assign max_upd = (s_sample >= max_reg) ? s_sample : max_reg;
    assign min_upd = (s_sample <= min_reg) ? s_sample : min_reg;

    // Only the word that closes a group needs room in the queue.
    assign last_sample = (index_reg == tmic_pkg::LAST_INDEX);
    assign s_ready     = !last_sample || !q_full;
    assign accept      = s_valid && s_ready;

    assign push           = accept && last_sample;
    assign push_data.sum  = sum_add;
    assign push_data.max  = max_upd;
    assign push_data.min  = min_upd;

    // Next state: accumulate, or clear once the group is complete.
    always_comb begin
        index_next = index_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        if (accept) begin
            if (last_sample) begin
                index_next = '0;
                sum_next   = '0;
                max_next   = '0;
                min_next   = tmic_pkg::MIN_INIT;
            end else begin
                index_next = index_reg + 1'b1;
                sum_next   = sum_add;
                max_next   = max_upd;
                min_next   = min_upd;
            end
        end
    end

    // Running state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= tmic_pkg::MIN_INIT;
        end else begin
            index_reg <= index_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
        end
    end

endmodule

/* hw/rtl/tmic_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmic_queue: group statistics queue
// A short first-in first-out queue that decouples the accumulator from the
// classifier so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tmic_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tmic_pkg::group_stats_t  push_data,
    output logic                    full,
    input  logic                    pop,
    output logic                    empty,
    output tmic_pkg::group_stats_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tmic_pkg::group_stats_t  entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/tmic_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmic_back: trimmed mean and classifier
// Takes one group's statistics from the queue, removes one maximum and one
// minimum, divides by eight, classifies the level and holds the result word.
// ----------------------------------------------------------------------------
module tmic_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  tmic_pkg::group_stats_t           q_head,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tmic_pkg::CLASS_W-1:0]     m_device_class,
    output logic [tmic_pkg::SAMPLE_W-1:0]    m_average_level
);

    logic                          valid_reg, valid_next;
    logic [tmic_pkg::CLASS_W-1:0]  class_reg;
    logic [tmic_pkg::SAMPLE_W-1:0] level_reg;
    logic [tmic_pkg::SUM_W-1:0]    trimmed;
    logic [tmic_pkg::SAMPLE_W-1:0] level;
    logic                          load;

    // The trimmed sum never exceeds eight full-scale samples, so the level
    // is bits 12..3 of it.
    assign trimmed = q_head.sum - tmic_pkg::SUM_W'(q_head.max)
                                - tmic_pkg::SUM_W'(q_head.min);
    assign level   = trimmed[tmic_pkg::SAMPLE_W+2:3];

    // Load a new result when the output register is free or being drained.
    assign load  = !q_empty && (!valid_reg || m_ready);
    assign q_pop = load;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            class_reg <= tmic_pkg::classify(level);
            level_reg <= level;
        end
    end

    assign m_valid         = valid_reg;
    assign m_device_class  = class_reg;
    assign m_average_level = level_reg;

endmodule

/* hw/rtl/trimmed_mean_id_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_id_classifier: module identification voltage classifier
// Averages groups of ten converter samples with one maximum and one minimum
// removed, and sorts the level into a module class code.
// ----------------------------------------------------------------------------
// The block takes one 10-bit sample word per clock cycle, with no gaps needed
// between groups: the accumulator updates its sum, maximum and minimum with
// each accepted sample. Every tenth sample produces one result word with the
// class code and the trimmed mean level, computed from the queued statistics
// and registered at the output. A queue of QUEUE_DEPTH group entries sits between
// the accumulator and the classifier, so the input keeps flowing while results
// wait on m_ready; the input stalls only on a closing sample when that queue is
// full. Class 0 means nothing attached, and levels of 207 or less give class 2.
// ----------------------------------------------------------------------------
module trimmed_mean_id_classifier #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tmic_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tmic_pkg::CLASS_W-1:0]     m_device_class,
    output logic [tmic_pkg::SAMPLE_W-1:0]    m_average_level
);

    logic                    push;
    tmic_pkg::group_stats_t  push_data;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_empty;
    tmic_pkg::group_stats_t  q_head;

    // Sample accumulator.
    tmic_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // Queue of completed groups.
    tmic_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Trimmed mean, classification and output register.
    tmic_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_device_class  (m_device_class),
        .m_average_level (m_average_level)
    );

endmodule
